[sv/mclw_pkg.sv]
// Shared types and constants for the multi-channel liveness watchdog.
// Command, event and status codes, register map, configuration and
// controller/datapath handshake structs. No dependencies.
package mclw_pkg;

    // Input commands
    localparam logic [2:0] CMD_RESET    = 3'd0;
    localparam logic [2:0] CMD_ACTIVITY = 3'd1;
    localparam logic [2:0] CMD_KICK     = 3'd2;
    localparam logic [2:0] CMD_QUERY    = 3'd3;
    localparam logic [2:0] CMD_SCAN     = 3'd4;

    // Result event codes
    localparam logic [1:0] EV_KICK    = 2'd0;
    localparam logic [1:0] EV_TIMEOUT = 2'd1;
    localparam logic [1:0] EV_QUERY   = 2'd2;

    // Channel status codes
    localparam logic [2:0] ST_UNUSED  = 3'd0;
    localparam logic [2:0] ST_OFFLINE = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_ALIVE   = 3'd3;
    localparam logic [2:0] ST_STUCK   = 3'd4;

    // Register map, index taken from paddr[4:3]
    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_SAMPLE  = 2'd1;
    localparam logic [1:0] REG_MONITOR = 2'd2;
    localparam logic [1:0] REG_ENABLE  = 2'd3;

    localparam logic [47:0] TIMEOUT_RST = 48'd1000000000;
    localparam logic [47:0] SAMPLE_RST  = 48'd1000000;
    localparam logic [3:0]  MONITOR_RST = 4'd8;
    localparam logic        ENABLE_RST  = 1'b1;

    localparam logic [31:0] KICK_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [47:0] timeout_ticks;
        logic [47:0] activity_sample_ticks;
        logic [3:0]  monitor_count;
        logic        report_enable;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic read;
        logic calc;
        logic eval;
        logic flush;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic skip;
        logic scan_more;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

[sv/mclw_cfg.sv]
// APB-style configuration register file for the liveness watchdog.
// Holds timeout, sampling interval, monitor count and report enable.
// Depends on mclw_pkg.
module mclw_cfg
    import mclw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks         <= TIMEOUT_RST;
            cfg_reg.activity_sample_ticks <= SAMPLE_RST;
            cfg_reg.monitor_count         <= MONITOR_RST;
            cfg_reg.report_enable         <= ENABLE_RST;
        end else if (wr_en) begin
            unique case (paddr[4:3])
                REG_TIMEOUT: cfg_reg.timeout_ticks         <= pwdata[47:0];
                REG_SAMPLE:  cfg_reg.activity_sample_ticks <= pwdata[47:0];
                REG_MONITOR: cfg_reg.monitor_count         <= pwdata[3:0];
                REG_ENABLE:  cfg_reg.report_enable         <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:3])
            REG_TIMEOUT: prdata = {16'd0, cfg_reg.timeout_ticks};
            REG_SAMPLE:  prdata = {16'd0, cfg_reg.activity_sample_ticks};
            REG_MONITOR: prdata = {60'd0, cfg_reg.monitor_count};
            REG_ENABLE:  prdata = {63'd0, cfg_reg.report_enable};
        endcase
    end

endmodule

[sv/mclw_datapath.sv]
// Datapath of the liveness watchdog: item registers, per-channel records,
// age subtract, status evaluation, pending result and output register.
// Depends on mclw_pkg; driven by mclw_ctrl commands.
module mclw_datapath
    import mclw_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    input  logic [2:0]  s_cmd,
    input  logic [2:0]  s_channel,
    input  logic [63:0] s_now_ticks,
    input  logic [63:0] s_token,
    input  logic [7:0]  s_present_mask,
    input  logic [7:0]  s_running_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_channel,
    output logic [1:0]  m_event_res,
    output logic [2:0]  m_status,
    output logic [63:0] m_age,
    output logic [31:0] m_kicks,
    output logic [63:0] m_last_token_out,
    output logic        m_last_of_run
);

    // Only channels 0..7 are addressable, so at most eight records exist
    localparam int NCH_STORE = (NUM_CHANNELS < 8) ? NUM_CHANNELS : 8;
    localparam int IDX_W     = (NCH_STORE > 1) ? $clog2(NCH_STORE) : 1;
    localparam logic [3:0] NCH_LIM = 4'(NCH_STORE);
    localparam logic [6:0] NCH_ALL = 7'(NUM_CHANNELS);

    // Per-channel records
    logic [63:0] act_mem_reg  [NCH_STORE];
    logic [31:0] kick_mem_reg [NCH_STORE];
    logic [63:0] tok_mem_reg  [NCH_STORE];
    logic [2:0]  rep_mem_reg  [NCH_STORE];

    // Item registers
    logic [2:0]  cmd_reg;
    logic [2:0]  ch_reg;
    logic [63:0] now_reg;
    logic [63:0] token_reg;
    logic [7:0]  present_reg;
    logic [7:0]  running_reg;

    // Record read and age
    logic [63:0] rd_act_reg;
    logic [31:0] rd_kicks_reg;
    logic [63:0] rd_tok_reg;
    logic [2:0]  rd_rep_reg;
    logic [63:0] age_reg;

    // Pending result
    logic        pend_valid_reg;
    logic [2:0]  pend_ch_reg;
    logic [1:0]  pend_ev_reg;
    logic [2:0]  pend_st_reg;
    logic [63:0] pend_age_reg;
    logic [31:0] pend_kicks_reg;
    logic [63:0] pend_tok_reg;

    // Output register
    logic        m_valid_reg;
    logic [2:0]  m_ch_reg;
    logic [1:0]  m_ev_reg;
    logic [2:0]  m_st_reg;
    logic [63:0] m_age_reg;
    logic [31:0] m_kicks_reg;
    logic [63:0] m_tok_reg;
    logic        m_last_reg;

    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    logic [3:0]       scan_lim;
    logic [3:0]       ch_plus;
    logic [64:0]      diff;
    logic             out_free;
    logic             skip;
    logic             scan_more;
    logic             present_bit;
    logic             running_bit;
    logic             age_gt;
    logic [31:0]      kick_next;
    logic [2:0]       st_next;
    logic [63:0]      age_next;
    logic [31:0]      kicks_next;
    logic [63:0]      tok_next;
    logic [1:0]       ev_next;
    logic             hit;
    logic             ch_in_range;

    assign scan_lim = (cfg.monitor_count < NCH_LIM) ? cfg.monitor_count : NCH_LIM;
    assign ch_plus  = {1'b0, ch_reg} + 4'd1;
    assign out_free = ~m_valid_reg | m_ready;
    assign ch_in_range = {4'd0, s_channel} < NCH_ALL;

    always_comb begin
        priority if (s_cmd > CMD_SCAN) begin
            skip = 1'b1;
        end else if (s_cmd == CMD_SCAN) begin
            skip = ~cfg.report_enable | (scan_lim == 4'd0);
        end else begin
            skip = ~ch_in_range;
        end
    end

    assign scan_more = (cmd_reg == CMD_SCAN) && (ch_plus < scan_lim);
    assign status    = '{skip: skip, scan_more: scan_more, pend_valid: pend_valid_reg,
                         out_free: out_free};

    assign rd_idx = cmd.load ? ((s_cmd == CMD_SCAN) ? '0 : s_channel[IDX_W-1:0])
                             : ch_reg[IDX_W-1:0];
    assign wr_idx = ch_reg[IDX_W-1:0];

    assign diff = {1'b0, now_reg} - {1'b0, rd_act_reg};

    // Snapshot and report decision
    assign present_bit = present_reg[ch_reg];
    assign running_bit = running_reg[ch_reg];
    assign age_gt      = age_reg > {16'd0, cfg.timeout_ticks};
    assign kick_next   = (rd_kicks_reg == KICK_MAX) ? rd_kicks_reg : rd_kicks_reg + 32'd1;

    always_comb begin
        ev_next    = (cmd_reg == CMD_KICK) ? EV_KICK
                   : ((cmd_reg == CMD_QUERY) ? EV_QUERY : EV_TIMEOUT);
        age_next   = 64'd0;
        kicks_next = 32'd0;
        tok_next   = 64'd0;
        priority if (!present_bit) begin
            st_next = ST_UNUSED;
        end else if (!running_bit) begin
            st_next = ST_OFFLINE;
        end else if (cmd_reg == CMD_KICK) begin
            // activity was just stamped, so age is zero and kicks nonzero
            st_next    = ST_ALIVE;
            kicks_next = kick_next;
            tok_next   = token_reg;
        end else begin
            st_next    = age_gt ? ST_STUCK : ((rd_kicks_reg == 32'd0) ? ST_UNKNOWN : ST_ALIVE);
            age_next   = age_reg;
            kicks_next = rd_kicks_reg;
            tok_next   = rd_tok_reg;
        end
        unique case (cmd_reg)
            CMD_KICK:  hit = ({1'b0, ch_reg} < cfg.monitor_count) && cfg.report_enable
                             && (st_next != ST_UNUSED);
            CMD_QUERY: hit = 1'b1;
            CMD_SCAN:  hit = (st_next == ST_STUCK) && (rd_rep_reg != ST_STUCK);
            default:   hit = 1'b0;
        endcase
    end

    // Records, pending and output valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NCH_STORE; i++) begin
                act_mem_reg[i]  <= 64'd0;
                kick_mem_reg[i] <= 32'd0;
                tok_mem_reg[i]  <= 64'd0;
                rep_mem_reg[i]  <= ST_UNUSED;
            end
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.eval) begin
                unique case (cmd_reg)
                    CMD_RESET: begin
                        act_mem_reg[wr_idx]  <= now_reg;
                        kick_mem_reg[wr_idx] <= 32'd0;
                        tok_mem_reg[wr_idx]  <= 64'd0;
                        rep_mem_reg[wr_idx]  <= ST_UNUSED;
                    end
                    CMD_ACTIVITY: begin
                        if (age_reg >= {16'd0, cfg.activity_sample_ticks}) begin
                            act_mem_reg[wr_idx] <= now_reg;
                        end
                    end
                    CMD_KICK: begin
                        act_mem_reg[wr_idx]  <= now_reg;
                        kick_mem_reg[wr_idx] <= kick_next;
                        tok_mem_reg[wr_idx]  <= token_reg;
                        if (hit) begin
                            rep_mem_reg[wr_idx] <= st_next;
                        end
                    end
                    CMD_SCAN: begin
                        if (hit) begin
                            rep_mem_reg[wr_idx] <= ST_STUCK;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            priority if ((cmd.eval && hit && pend_valid_reg) || cmd.flush) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.eval && hit) begin
                pend_valid_reg <= 1'b1;
            end else if (cmd.flush) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg     <= s_cmd;
            ch_reg      <= (s_cmd == CMD_SCAN) ? 3'd0 : s_channel;
            now_reg     <= s_now_ticks;
            token_reg   <= s_token;
            present_reg <= s_present_mask;
            running_reg <= s_running_mask;
        end else if (cmd.eval && scan_more) begin
            ch_reg <= ch_plus[2:0];
        end
        if (cmd.load || cmd.read) begin
            rd_act_reg   <= act_mem_reg[rd_idx];
            rd_kicks_reg <= kick_mem_reg[rd_idx];
            rd_tok_reg   <= tok_mem_reg[rd_idx];
            rd_rep_reg   <= rep_mem_reg[rd_idx];
        end
        if (cmd.calc) begin
            // clamp to zero when the clock is behind the stamp
            age_reg <= diff[64] ? 64'd0 : diff[63:0];
        end
        if (cmd.eval && hit) begin
            pend_ch_reg    <= ch_reg;
            pend_ev_reg    <= ev_next;
            pend_st_reg    <= st_next;
            pend_age_reg   <= age_next;
            pend_kicks_reg <= kicks_next;
            pend_tok_reg   <= tok_next;
        end
        // pending result moves out: not last when displaced, last on flush
        if ((cmd.eval && hit && pend_valid_reg) || cmd.flush) begin
            m_ch_reg    <= pend_ch_reg;
            m_ev_reg    <= pend_ev_reg;
            m_st_reg    <= pend_st_reg;
            m_age_reg   <= pend_age_reg;
            m_kicks_reg <= pend_kicks_reg;
            m_tok_reg   <= pend_tok_reg;
            m_last_reg  <= cmd.flush;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_channel    = m_ch_reg;
    assign m_event_res      = m_ev_reg;
    assign m_status         = m_st_reg;
    assign m_age            = m_age_reg;
    assign m_kicks          = m_kicks_reg;
    assign m_last_token_out = m_tok_reg;
    assign m_last_of_run    = m_last_reg;

endmodule

[sv/mclw_ctrl.sv]
// Controller of the liveness watchdog: sequences accept, record read,
// age subtract, evaluation, scan stepping and final flush.
// Depends on mclw_pkg; commands mclw_datapath.
module mclw_ctrl
    import mclw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CALC,
        S_EVAL,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   eval_go;

    // a new result displaces the pending one only if the output can take it
    assign eval_go = ~status.pend_valid | status.out_free;
    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (!status.skip) begin
                        state_next = S_CALC;
                    end
                end
            end
            S_READ: begin
                cmd.read   = 1'b1;
                state_next = S_CALC;
            end
            S_CALC: begin
                cmd.calc   = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (eval_go) begin
                    cmd.eval   = 1'b1;
                    state_next = status.scan_more ? S_READ : S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!status.pend_valid) begin
                    state_next = S_IDLE;
                end else if (status.out_free) begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[sv/multi_channel_liveness_watchdog.sv]
// Multi-channel liveness watchdog, top level.
// Input channel s_*: one command per transaction (reset, activity, kick,
// query, scan) with time stamp, token and present/running masks.
// Result channel m_*: kick reports, timeout reports and query answers;
// m_last_of_run marks the last result of a command.
// APB port: timeout, sampling interval, monitor count, report enable.
// Sequence: a command passes through accept, age subtract, evaluate and
// flush before the block takes the next one; ignored commands are only
// accepted. A scan repeats read, age subtract and evaluate per further
// monitored channel (the accept reads channel 0) on the single shared
// record read, 64-bit age subtract and evaluation path of all channels.
// A result reaches m_valid by the flush after its evaluation (kick, query)
// or when the next result of the same scan displaces it.
// The output register and a pending stage decouple the sides: the next
// command is accepted while a result still waits; a stalled receiver holds
// further results, and the controller waits in evaluate or flush.
// Reset (aresetn low, synchronous) clears all channel records and restores
// the register defaults; no clearing pass is needed.
// Depends on mclw_pkg, mclw_cfg, mclw_ctrl and mclw_datapath.
module multi_channel_liveness_watchdog
    import mclw_pkg::*;
#(
    parameter int NUM_CHANNELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [2:0]  s_channel,
    input  logic [63:0] s_now_ticks,
    input  logic [63:0] s_token,
    input  logic [7:0]  s_present_mask,
    input  logic [7:0]  s_running_mask,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_out_channel,
    output logic [1:0]  m_event_res,
    output logic [2:0]  m_status,
    output logic [63:0] m_age,
    output logic [31:0] m_kicks,
    output logic [63:0] m_last_token_out,
    output logic        m_last_of_run
);

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    mclw_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mclw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mclw_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .cmd              (cmd),
        .status           (status),
        .s_cmd            (s_cmd),
        .s_channel        (s_channel),
        .s_now_ticks      (s_now_ticks),
        .s_token          (s_token),
        .s_present_mask   (s_present_mask),
        .s_running_mask   (s_running_mask),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_channel    (m_out_channel),
        .m_event_res      (m_event_res),
        .m_status         (m_status),
        .m_age            (m_age),
        .m_kicks          (m_kicks),
        .m_last_token_out (m_last_token_out),
        .m_last_of_run    (m_last_of_run)
    );

endmodule
